// File: hw/rtl/tsc_pkg.sv
// Shared types, constants and helper functions of the trajectory smoothing block.
// No dependencies; every other file of the block refers to this package by scope.
`default_nettype none

package tsc_pkg;

    localparam int RAD_W  = 5;   // radius register and frame distance width
    localparam int SPAN_W = 6;   // window span, at most twice the radius
    localparam int CNT_W  = 7;   // frames seen in a sequence, saturating
    localparam int SUM_W  = 40;  // window sum width

    localparam logic [RAD_W-1:0] RADIUS_RESET = 5'd15;
    localparam logic [CNT_W-1:0] COUNT_CAP    = 7'd127;

    typedef struct packed {
        logic signed [23:0] delta_x;
        logic signed [23:0] delta_y;
        logic signed [15:0] delta_rot;
        logic               last_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] corrected_dx;
        logic signed [31:0] corrected_dy;
        logic signed [31:0] corrected_dangle;
        logic        [30:0] peak_dev_x;
        logic        [30:0] peak_dev_y;
        logic               last_result;
    } out_item_t;

    // One ring entry: the frame delta and the path value after it
    typedef struct packed {
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [15:0] da;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pa;
    } ring_entry_t;

    // Request from the front part to the back part
    typedef struct packed {
        logic              wr;        // store the entry in the rings
        logic              emit;      // form one result
        logic              fin;       // final result of the sequence
        logic [RAD_W-1:0]  back_dist; // result frame distance behind the newest frame
        logic [SPAN_W-1:0] span;      // window reaches this far behind the newest frame
        ring_entry_t       entry;
    } cmd_t;

    // Back part handshake status, watched at the top level
    typedef struct packed {
        logic pop;
        logic load;
    } back_stat_t;

    // Clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh07FFFFFFF;
        lo = -36'sh080000000;
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Window span for the frame back_dist behind newest frame t, radius r
    function automatic logic [SPAN_W-1:0] span_of(input logic [CNT_W-1:0] t,
                                                  input logic [RAD_W-1:0] back_dist,
                                                  input logic [RAD_W-1:0] r);
        logic [CNT_W-1:0] k;
        logic [RAD_W-1:0] lo;
        k  = t - {2'b00, back_dist};
        lo = (k < {2'b00, r}) ? k[RAD_W-1:0] : r;
        return {1'b0, back_dist} + {1'b0, lo};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tsc_front.sv
// Front part: accepts frames, keeps the saturating path sums and frame count,
// and issues ring writes and result requests. Depends on tsc_pkg.
`default_nettype none

module tsc_front #(
    parameter int RING_DEPTH = 64,
    parameter int MAX_RADIUS = 31
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [tsc_pkg::RAD_W-1:0]  radius,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire tsc_pkg::in_item_t          item,
    output logic                            push,
    output tsc_pkg::cmd_t                   cmd,
    input  wire logic                       full
);

    localparam int R_LIM = (MAX_RADIUS < (RING_DEPTH - 1) / 2) ? MAX_RADIUS
                                                               : (RING_DEPTH - 1) / 2;
    localparam logic [tsc_pkg::RAD_W-1:0] R_MAX = tsc_pkg::RAD_W'(R_LIM);

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_FLUSH = 2'b10
    } fstate_t;

    fstate_t                     state_reg;
    logic [tsc_pkg::CNT_W-1:0]   t_reg;
    logic [tsc_pkg::CNT_W-1:0]   ft_reg;
    logic [tsc_pkg::RAD_W-1:0]   r_reg;
    logic [tsc_pkg::RAD_W-1:0]   fd_reg;
    logic signed [31:0]          sum_x_reg;
    logic signed [31:0]          sum_y_reg;
    logic signed [31:0]          sum_a_reg;

    logic                        accept;
    logic [tsc_pkg::RAD_W-1:0]   r_cur;
    logic [tsc_pkg::RAD_W-1:0]   d_cur;
    logic signed [31:0]          sum_x_next;
    logic signed [31:0]          sum_y_next;
    logic signed [31:0]          sum_a_next;

    assign item_stall = (state_reg == F_FLUSH) || full;
    assign accept     = item_valid && !item_stall;

    // Latch the radius on the first frame of a sequence
    assign r_cur = (t_reg == '0) ? ((radius > R_MAX) ? R_MAX : radius) : r_reg;

    // Accumulate the camera path with saturation
    assign sum_x_next = tsc_pkg::sat32(36'(sum_x_reg) + 36'(item.delta_x));
    assign sum_y_next = tsc_pkg::sat32(36'(sum_y_reg) + 36'(item.delta_y));
    assign sum_a_next = tsc_pkg::sat32(36'(sum_a_reg) + 36'(item.delta_rot));

    // Oldest pending result distance: the radius, or fewer on a short sequence
    always_comb
    begin
        if (!item.last_frame)
            d_cur = r_cur;
        else if (t_reg < {2'b00, r_cur})
            d_cur = t_reg[tsc_pkg::RAD_W-1:0];
        else
            d_cur = r_cur;
    end

    // Build the request for the queue
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                push           = accept;
                cmd.wr         = 1'b1;
                cmd.emit       = item.last_frame || (t_reg >= {2'b00, r_cur});
                cmd.fin        = item.last_frame && (d_cur == '0);
                cmd.back_dist  = d_cur;
                cmd.span       = tsc_pkg::span_of(t_reg, d_cur, r_cur);
                cmd.entry.dx   = item.delta_x;
                cmd.entry.dy   = item.delta_y;
                cmd.entry.da   = item.delta_rot;
                cmd.entry.px   = sum_x_next;
                cmd.entry.py   = sum_y_next;
                cmd.entry.pa   = sum_a_next;
            end
            F_FLUSH:
            begin
                push          = !full;
                cmd.emit      = 1'b1;
                cmd.fin       = (fd_reg == '0);
                cmd.back_dist = fd_reg;
                cmd.span      = tsc_pkg::span_of(ft_reg, fd_reg, r_reg);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Advance the sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            t_reg     <= '0;
            ft_reg    <= '0;
            r_reg     <= '0;
            fd_reg    <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_a_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        r_reg <= r_cur;
                        if (item.last_frame)
                        begin
                            // Clear the sequence; drain the remaining results
                            sum_x_reg <= '0;
                            sum_y_reg <= '0;
                            sum_a_reg <= '0;
                            t_reg     <= '0;
                            if (d_cur != '0)
                            begin
                                state_reg <= F_FLUSH;
                                fd_reg    <= d_cur - 1'b1;
                                ft_reg    <= t_reg;
                            end
                        end
                        else
                        begin
                            sum_x_reg <= sum_x_next;
                            sum_y_reg <= sum_y_next;
                            sum_a_reg <= sum_a_next;
                            if (t_reg != tsc_pkg::COUNT_CAP)
                                t_reg <= t_reg + 1'b1;
                        end
                    end
                end
                F_FLUSH:
                begin
                    if (!full)
                    begin
                        fd_reg <= fd_reg - 1'b1;
                        if (fd_reg == '0)
                            state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tsc_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on tsc_pkg for the request type.
`default_nettype none

module tsc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tsc_pkg::cmd_t  din,
    output logic                full,
    input  wire logic           pop,
    output tsc_pkg::cmd_t       dout,
    output logic                empty
);

    tsc_pkg::cmd_t  slot_reg [2];
    logic           wp_reg;
    logic           rp_reg;
    logic [1:0]     fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign dout  = slot_reg[rp_reg];

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wp_reg] <= din;
    end

    // Track fill level and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= !wp_reg;
            if (pop && !empty)
                rp_reg <= !rp_reg;
            fill_reg <= fill_reg + 2'((push && !full) ? 1 : 0)
                                 - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tsc_back.sv
// Back part: holds the delta and path rings, sums each window over the ring,
// divides by the window count bit-serially and forms the corrected result.
// Depends on tsc_pkg.
`default_nettype none

module tsc_back #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tsc_pkg::cmd_t       cmd,
    input  wire logic                empty,
    output tsc_pkg::back_stat_t      stat,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output tsc_pkg::out_item_t       result
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);
    localparam int SW = tsc_pkg::SUM_W;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_SCAN = 4'b0010,
        B_DIV  = 4'b0100,
        B_DONE = 4'b1000
    } bstate_t;

    tsc_pkg::ring_entry_t ring_mem [RING_DEPTH];

    bstate_t                       state_reg;
    logic [PW-1:0]                 wptr_reg;
    logic [PW-1:0]                 newest_reg;
    logic [PW-1:0]                 q_reg;
    logic [tsc_pkg::SPAN_W-1:0]    idx_reg;
    logic [tsc_pkg::SPAN_W-1:0]    span_reg;
    logic [tsc_pkg::RAD_W-1:0]     dist_reg;
    logic                          fin_reg;
    logic                          rd_v_reg;
    logic                          rd_cap_reg;
    tsc_pkg::ring_entry_t          rd_data_reg;
    tsc_pkg::ring_entry_t          cap_reg;
    logic signed [SW-1:0]          sum_reg [3];
    logic [SW-1:0]                 a_reg   [3];
    logic [tsc_pkg::SPAN_W-1:0]    rem_reg [3];
    logic                          neg_reg [3];
    logic [5:0]                    cnt_reg;
    logic [30:0]                   max_x_reg;
    logic [30:0]                   max_y_reg;
    logic                          out_valid_reg;
    tsc_pkg::out_item_t            out_reg;

    logic                          scan_issue;
    logic                          pop;
    logic                          load;
    logic [tsc_pkg::SPAN_W:0]      divisor;
    logic [SW-1:0]                 a_next   [3];
    logic [tsc_pkg::SPAN_W-1:0]    rem_next [3];
    logic signed [33:0]            avg      [3];
    logic signed [33:0]            diff     [3];
    logic signed [31:0]            corr     [3];
    logic [30:0]                   max_x_next;
    logic [30:0]                   max_y_next;

    assign pop          = (state_reg == B_IDLE) && !empty;
    assign scan_issue   = (state_reg == B_SCAN) && (idx_reg <= span_reg);
    assign load         = (state_reg == B_DONE) && (!out_valid_reg || !result_stall);
    assign stat.pop     = pop;
    assign stat.load    = load;
    assign divisor      = {1'b0, span_reg} + 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Ring write and registered read
    always_ff @(posedge clk)
    begin
        if (pop && cmd.wr)
            ring_mem[wptr_reg] <= cmd.entry;
        rd_data_reg <= ring_mem[q_reg];
    end

    // One restoring division step on each lane
    always_comb
    begin
        logic [tsc_pkg::SPAN_W:0] trial;
        logic                     ge;
        for (int i = 0; i < 3; i++)
        begin
            trial       = {rem_reg[i], a_reg[i][SW-1]};
            ge          = (trial >= divisor);
            rem_next[i] = ge ? tsc_pkg::SPAN_W'(trial - divisor)
                             : trial[tsc_pkg::SPAN_W-1:0];
            a_next[i]   = {a_reg[i][SW-2:0], ge};
        end
    end

    // Apply sign to the quotient; form the difference and the corrected value
    always_comb
    begin
        logic signed [SW:0] q;
        logic signed [33:0] path [3];
        logic signed [35:0] delta [3];
        path[0]  = 34'(cap_reg.px);
        path[1]  = 34'(cap_reg.py);
        path[2]  = 34'(cap_reg.pa);
        delta[0] = 36'(cap_reg.dx);
        delta[1] = 36'(cap_reg.dy);
        delta[2] = 36'(cap_reg.da);
        for (int i = 0; i < 3; i++)
        begin
            q       = neg_reg[i] ? -$signed({1'b0, a_reg[i]}) : $signed({1'b0, a_reg[i]});
            avg[i]  = q[33:0];
            diff[i] = avg[i] - path[i];
            corr[i] = tsc_pkg::sat32(delta[i] + 36'(diff[i]));
        end
    end

    // Raise the running maxima with the positive differences
    always_comb
    begin
        logic [30:0] cx;
        logic [30:0] cy;
        cx = (diff[0] > 34'sh07FFFFFFF) ? 31'h7FFFFFFF : diff[0][30:0];
        cy = (diff[1] > 34'sh07FFFFFFF) ? 31'h7FFFFFFF : diff[1][30:0];
        max_x_next = (diff[0] > $signed({3'b000, max_x_reg})) ? cx : max_x_reg;
        max_y_next = (diff[1] > $signed({3'b000, max_y_reg})) ? cy : max_y_reg;
    end

    // Sequence the scan, division and result hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            wptr_reg   <= '0;
            newest_reg <= '0;
            q_reg      <= '0;
            idx_reg    <= '0;
            span_reg   <= '0;
            dist_reg   <= '0;
            fin_reg    <= 1'b0;
            rd_v_reg   <= 1'b0;
            rd_cap_reg <= 1'b0;
            cnt_reg    <= '0;
            max_x_reg  <= '0;
            max_y_reg  <= '0;
        end
        else
        begin
            rd_v_reg   <= scan_issue;
            rd_cap_reg <= scan_issue && (idx_reg == {1'b0, dist_reg});
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        if (cmd.wr)
                        begin
                            newest_reg <= wptr_reg;
                            wptr_reg   <= (wptr_reg == LAST_POS) ? '0 : wptr_reg + 1'b1;
                        end
                        if (cmd.emit)
                        begin
                            q_reg     <= cmd.wr ? wptr_reg : newest_reg;
                            idx_reg   <= '0;
                            span_reg  <= cmd.span;
                            dist_reg  <= cmd.back_dist;
                            fin_reg   <= cmd.fin;
                            state_reg <= B_SCAN;
                        end
                    end
                end
                B_SCAN:
                begin
                    if (scan_issue)
                    begin
                        q_reg   <= (q_reg == '0) ? LAST_POS : q_reg - 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (!rd_v_reg)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'(SW - 1))
                        state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    if (load)
                    begin
                        state_reg <= B_IDLE;
                        if (fin_reg)
                        begin
                            max_x_reg <= '0;
                            max_y_reg <= '0;
                            wptr_reg  <= '0;
                        end
                        else
                        begin
                            max_x_reg <= max_x_next;
                            max_y_reg <= max_y_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Window sums, captured frame and divider lanes
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
        end
        else if (state_reg == B_SCAN)
        begin
            if (rd_v_reg)
            begin
                sum_reg[0] <= sum_reg[0] + SW'(rd_data_reg.px);
                sum_reg[1] <= sum_reg[1] + SW'(rd_data_reg.py);
                sum_reg[2] <= sum_reg[2] + SW'(rd_data_reg.pa);
            end
            if (rd_cap_reg)
                cap_reg <= rd_data_reg;
            // Load magnitudes into the divider once the last read is summed
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= sum_reg[i][SW-1];
                a_reg[i]   <= sum_reg[i][SW-1] ? SW'(-sum_reg[i]) : sum_reg[i];
                rem_reg[i] <= '0;
            end
        end
        else if (state_reg == B_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]   <= a_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.corrected_dx     <= corr[0];
            out_reg.corrected_dy     <= corr[1];
            out_reg.corrected_dangle <= corr[2];
            out_reg.peak_dev_x       <= max_x_next;
            out_reg.peak_dev_y       <= max_y_next;
            out_reg.last_result      <= fin_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/trajectory_smoothing_correction.sv
// Top level of the trajectory smoothing block: radius register, front part,
// request queue and back part. Depends on tsc_pkg, tsc_front, tsc_queue, tsc_back.
//
// Each frame's x, y and angle deltas are summed into a camera path; the path is
// smoothed by a centred moving average of radius r (latched on the first frame
// of a sequence, limited to MAX_RADIUS and (RING_DEPTH-1)/2) and each result,
// delta + smoothed - path, leaves r frames late; a frame with last_frame set
// releases all pending results, the final one flagged by last_result, and then
// clears the sequence. The window, whose span (up to 2r) is its length minus one,
// is summed one ring entry per cycle over the single read port, and the three
// window averages come from bit-serial dividers. A two-entry request queue lets
// the front accept the next frame while the back is still working on a result.
`default_nettype none

module trajectory_smoothing_correction #(
    parameter int RING_DEPTH = 64,
    parameter int MAX_RADIUS = 31
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      radius_we,
    input  wire logic [tsc_pkg::RAD_W-1:0] radius_data,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire tsc_pkg::in_item_t         item,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output tsc_pkg::out_item_t             result
);

    logic [tsc_pkg::RAD_W-1:0] radius_reg;
    logic                      q_push;
    logic                      q_full;
    logic                      q_empty;
    tsc_pkg::cmd_t             q_din;
    tsc_pkg::cmd_t             q_dout;
    tsc_pkg::back_stat_t       b_stat;

    // Hold the smoothing radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= tsc_pkg::RADIUS_RESET;
        else if (radius_we)
            radius_reg <= radius_data;
    end

    tsc_front #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .radius     (radius_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (q_push),
        .cmd        (q_din),
        .full       (q_full)
    );

    tsc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (b_stat.pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    tsc_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (q_dout),
        .empty        (q_empty),
        .stat         (b_stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Front never pushes a request into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

    // Back only pops a request that is there
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.pop |-> !q_empty)
        else $error("request popped from empty queue");

    // A new result never overwrites one that is still stalled
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.load |-> !(result_valid && result_stall))
        else $error("result loaded over a stalled result");

    // An accepted frame always leaves a request behind
    a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |-> q_push)
        else $error("accepted frame without request");

endmodule

`default_nettype wire

// File: tb/tsc_checker.sv
// Checker for trajectory_smoothing_correction: watches the radius port and both
// request channels, predicts each result and compares it. Depends on tsc_pkg.
`timescale 1ns / 100ps

module tsc_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      radius_we,
    input  wire logic [tsc_pkg::RAD_W-1:0] radius_data,
    input  wire logic                      item_valid,
    input  wire logic                      item_stall,
    input  wire tsc_pkg::in_item_t         item,
    input  wire logic                      result_valid,
    input  wire logic                      result_stall,
    input  wire tsc_pkg::out_item_t        result,
    output int                             errors,
    output int                             pending
);

    localparam int DEPTH = 64;
    localparam int RAD_LIMIT = 31;

    // Shadow of the block's sequence state
    longint delta_x_mem [DEPTH];
    longint delta_y_mem [DEPTH];
    longint delta_a_mem [DEPTH];
    longint path_x_mem [DEPTH];
    longint path_y_mem [DEPTH];
    longint path_a_mem [DEPTH];
    longint path_x, path_y, path_a;
    longint peak_x, peak_y;
    int     write_pos, frames_seen, seq_radius;
    logic [tsc_pkg::RAD_W-1:0] radius_reg;
    tsc_pkg::out_item_t expected_results [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void clear_sequence();
        path_x = 0; path_y = 0; path_a = 0;
        peak_x = 0; peak_y = 0;
        write_pos = 0; frames_seen = 0; seq_radius = 0;
    endfunction

    // Form the corrected result for the frame back_dist behind the newest frame
    function automatic void push_correction(int t, int back_dist, bit fin);
        int                 k, lo, span, pos, q;
        longint             sx, sy, sa, cnt, dx, dy, da;
        tsc_pkg::out_item_t r;
        k = t - back_dist;
        lo = (k < seq_radius) ? k : seq_radius;
        span = back_dist + lo;
        cnt = span + 1;
        pos = (write_pos - back_dist + DEPTH) % DEPTH;
        sx = 0; sy = 0; sa = 0;
        for (int i = 0; i <= span; i++)
        begin
            q = (write_pos - i + DEPTH) % DEPTH;
            sx += path_x_mem[q];
            sy += path_y_mem[q];
            sa += path_a_mem[q];
        end
        dx = sx / cnt - path_x_mem[pos];
        dy = sy / cnt - path_y_mem[pos];
        da = sa / cnt - path_a_mem[pos];
        if (dx > 64'sd2147483647) dx = 64'sd2147483647;
        if (dy > 64'sd2147483647) dy = 64'sd2147483647;
        if (dx > peak_x) peak_x = dx;
        if (dy > peak_y) peak_y = dy;
        dx = sx / cnt - path_x_mem[pos];
        dy = sy / cnt - path_y_mem[pos];
        r.corrected_dx     = 32'(clamp32(delta_x_mem[pos] + dx));
        r.corrected_dy     = 32'(clamp32(delta_y_mem[pos] + dy));
        r.corrected_dangle = 32'(clamp32(delta_a_mem[pos] + da));
        r.peak_dev_x       = 31'(peak_x);
        r.peak_dev_y       = 31'(peak_y);
        r.last_result      = fin;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Advance the shadow state by one frame and queue its results
    function automatic void predict_frame(tsc_pkg::in_item_t f);
        int t, d;
        t = frames_seen;
        if (t == 0)
            seq_radius = (int'(radius_reg) > RAD_LIMIT) ? RAD_LIMIT : int'(radius_reg);
        delta_x_mem[write_pos] = longint'(f.delta_x);
        delta_y_mem[write_pos] = longint'(f.delta_y);
        delta_a_mem[write_pos] = longint'(f.delta_rot);
        path_x = clamp32(path_x + longint'(f.delta_x));
        path_y = clamp32(path_y + longint'(f.delta_y));
        path_a = clamp32(path_a + longint'(f.delta_rot));
        path_x_mem[write_pos] = path_x;
        path_y_mem[write_pos] = path_y;
        path_a_mem[write_pos] = path_a;
        if (f.last_frame)
        begin
            d = (t < seq_radius) ? t : seq_radius;
            for (int j = d; j >= 0; j--)
                push_correction(t, j, j == 0);
            clear_sequence();
            return;
        end
        if (t >= seq_radius)
            push_correction(t, seq_radius, 1'b0);
        write_pos = (write_pos + 1) % DEPTH;
        if (frames_seen < int'(tsc_pkg::COUNT_CAP))
            frames_seen++;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // Track requests on every channel
    always @(posedge clk or negedge rst_n)
    begin
        tsc_pkg::out_item_t e;
        if (!rst_n)
        begin
            clear_sequence();
            radius_reg = tsc_pkg::RADIUS_RESET;
            expected_results.delete();
            errors = 0;
        end
        else
        begin
            if (radius_we)
                radius_reg = radius_data;
            if (item_valid && !item_stall)
                predict_frame(item);
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("corrected_dx", e.corrected_dx, result.corrected_dx);
                    check_field("corrected_dy", e.corrected_dy, result.corrected_dy);
                    check_field("corrected_dangle", e.corrected_dangle,
                                result.corrected_dangle);
                    check_field("peak_dev_x", e.peak_dev_x, result.peak_dev_x);
                    check_field("peak_dev_y", e.peak_dev_y, result.peak_dev_y);
                    check_field("last_result", e.last_result, result.last_result);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the trajectory_smoothing_correction testbench: clock, reset, frame
// stimulus, radius writes and verdict. Depends on tsc_pkg and tsc_checker.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 200;
    localparam int TOTAL_FRAMES = 150;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      radius_we = 1'b0;
    logic [tsc_pkg::RAD_W-1:0] radius_data = '0;
    logic                      item_valid = 1'b0;
    logic                      item_stall;
    tsc_pkg::in_item_t         item = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    tsc_pkg::out_item_t        result;
    int                        errors;
    int                        pending;
    int                        cycles = 0;
    int                        stall_left = 0;
    int                        frames_sent = 0;
    bit                        quiet = 1'b0;

    trajectory_smoothing_correction u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .radius_we    (radius_we),
        .radius_data  (radius_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    tsc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .radius_we    (radius_we),
        .radius_data  (radius_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    always #10 clk = ~clk;

    // Stall the result side in short random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one frame request and hold it until accepted
    task automatic send_frame(tsc_pkg::in_item_t f);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= f;
        do
            @(posedge clk);
        while (item_stall);
        frames_sent++;
        @(negedge clk);
    endtask

    // Drop valid and let all outstanding results drain
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_radius(int r);
        wait_idle();
        radius_we <= 1'b1;
        radius_data <= tsc_pkg::RAD_W'(r);
        @(negedge clk);
        radius_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic tsc_pkg::in_item_t make_frame(bit fin);
        tsc_pkg::in_item_t f;
        if ($urandom_range(0, 1))
        begin
            f.delta_x = 24'($urandom);
            f.delta_y = 24'($urandom);
            f.delta_rot = 16'($urandom);
        end
        else
        begin
            f.delta_x = 24'($urandom_range(0, 4000)) - 24'sd2000;
            f.delta_y = 24'($urandom_range(0, 4000)) - 24'sd2000;
            f.delta_rot = 16'($urandom_range(0, 400)) - 16'sd200;
        end
        f.last_frame = fin;
        return f;
    endfunction

    task automatic send_sequence(int len);
        for (int i = 0; i < len; i++)
            send_frame(make_frame(i == len - 1));
    endtask

    initial
    begin
        tsc_pkg::in_item_t f;
        int len;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset radius: flush before the radius is reached, extremes of deltas
        send_frame('{24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 1'b0});
        send_frame('{24'sh800000, 24'sh7FFFFF, 16'sh8000, 1'b0});
        send_frame('{24'sd0, 24'sd0, 16'sd0, 1'b1});
        // Single-frame sequence
        send_frame('{24'sd512, -24'sd256, 16'sd100, 1'b1});

        // Radius zero: every frame yields its own result
        write_radius(0);
        send_frame('{24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 1'b0});
        send_frame('{24'sh800000, 24'sh800000, 16'sh8000, 1'b0});
        send_frame('{24'sd3, -24'sd3, -16'sd1, 1'b1});

        // Widest radius, full flush of 32 results
        write_radius(31);
        send_sequence(36);

        // Radius written mid-sequence applies to the next sequence only
        write_radius(3);
        send_frame(make_frame(1'b0));
        send_frame(make_frame(1'b0));
        write_radius(7);
        send_sequence(6);
        send_sequence(10);

        // Run of maximum deltas, then a reversal, with radius one
        write_radius(1);
        for (int i = 0; i < 40; i++)
        begin
            f = '{24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 1'b0};
            if (i >= 36)
                f = '{24'sh800000, 24'sh7FFFFF, 16'sh8000, i == 39};
            send_frame(f);
        end

        // Random sequences with occasional radius changes
        while (frames_sent < TOTAL_FRAMES)
        begin
            if (frames_sent > 120)
                quiet = 1'b1;
            if ($urandom_range(0, 3) == 0)
                write_radius($urandom_range(0, 3) == 0 ? 31 : $urandom_range(0, 8));
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
            if (len > TOTAL_FRAMES - frames_sent)
                len = TOTAL_FRAMES - frames_sent;
            send_sequence(len);
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_queue.sv
hw/rtl/tsc_back.sv
hw/rtl/trajectory_smoothing_correction.sv
tb/tsc_checker.sv
tb/testbench.sv
